[rtl/core/pic_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    localparam int NUM_LINES = 8;

    localparam logic [7:0] PORT_BASE   = 8'hB0;
    localparam logic [7:0] PORT_ENABLE = 8'hB2;
    localparam logic [7:0] PORT_STATUS = 8'hB6;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RAISE = 2'd2,
        CMD_CHECK = 2'd3
    } t_pic_cmd;

    typedef struct packed {
        t_pic_cmd    cmd;
        logic [7:0]  port_addr;
        logic [7:0]  write_data;
        logic [2:0]  line_number;
    } t_pic_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        take_interrupt;
        logic [10:0] vector_address;
    } t_pic_out;

    // Per-line update controls for one accepted request.
    typedef struct packed {
        logic load_en;
        logic en_bit;
        logic clr;
        logic raise;
    } t_pic_cell_ctl;

endpackage

`default_nettype wire

[rtl/core/priority_interrupt_controller.sv]
// Eight-line priority interrupt controller.
// Input channel: i_in_valid / o_in_stall carry one request (t_pic_in) per
// cycle while o_in_stall is low: a bus write, a bus read, a line raise or an interrupt check.
// Output channel: o_out_valid / i_out_stall carry exactly one response
// (t_pic_out) for every accepted request, in request order.
// The response is registered in the output register, or first in the skid
// register when the output is stalled. Throughput is one request per cycle
// while o_in_stall is low; the line state lives in a chain of eight cells
// whose priority chain settles within the cycle.
// When the receiver stalls, the held response stays on the output and one
// further response is caught in a skid register; only then does o_in_stall
// rise, and it falls as soon as the output drains.
// Reset (i_rst_n low, synchronous) clears the pending bits, the enable mask,
// the vector base and both output stages.
`timescale 1ns / 1ps
`default_nettype none

module priority_interrupt_controller
    import pic_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_pic_in i_in_req,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_pic_out     o_out_rsp
);

    logic                 accept;
    logic                 wr_req;
    logic [7:0]           r_vec_base;
    t_pic_cell_ctl        cell_ctl [NUM_LINES];
    logic [NUM_LINES:0]   found_chain;
    logic [NUM_LINES-1:0] win_vec;
    logic [NUM_LINES-1:0] en_vec;
    logic [2:0]           win_idx;
    logic [8:0]           vec_sum;
    t_pic_out             rsp;

    logic                 r_out_valid;
    t_pic_out             r_out_rsp;
    logic                 r_skid_valid;
    t_pic_out             r_skid_rsp;
    logic                 out_free;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid & ~r_skid_valid;
    assign wr_req     = accept && (i_in_req.cmd == CMD_WRITE);

    always_comb begin
        for (int k = 0; k < NUM_LINES; k++) begin
            cell_ctl[k].load_en = wr_req && (i_in_req.port_addr == PORT_ENABLE);
            cell_ctl[k].en_bit  = i_in_req.write_data[k];
            cell_ctl[k].clr     = wr_req && (i_in_req.port_addr == PORT_STATUS)
                                  && i_in_req.write_data[k];
            cell_ctl[k].raise   = accept && (i_in_req.cmd == CMD_RAISE)
                                  && (i_in_req.line_number == 3'(k));
        end
    end

    assign found_chain[0] = 1'b0;

    for (genvar g = 0; g < NUM_LINES; g++) begin : g_line
        pic_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (cell_ctl[g]),
            .i_found  (found_chain[g]),
            .o_found  (found_chain[g+1]),
            .o_win    (win_vec[g]),
            .o_enable (en_vec[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_base <= 8'h00;
        end else if (wr_req && (i_in_req.port_addr == PORT_BASE)) begin
            r_vec_base <= i_in_req.write_data;
        end
    end

    always_comb begin
        win_idx = 3'd0;
        for (int k = 0; k < NUM_LINES; k++) begin
            if (win_vec[k]) begin
                win_idx = win_idx | 3'(k);
            end
        end
    end

    assign vec_sum = {1'b0, r_vec_base} + {6'd0, win_idx};

    always_comb begin
        rsp = '0;
        case (i_in_req.cmd)
            CMD_READ: begin
                case (i_in_req.port_addr)
                    PORT_BASE:   rsp.read_data = r_vec_base;
                    PORT_ENABLE: rsp.read_data = en_vec;
                    // With nothing pending the status port reads as line zero.
                    PORT_STATUS: rsp.read_data = found_chain[NUM_LINES] ? win_vec
                                                                        : 8'h01;
                    default:     rsp.read_data = 8'h00;
                endcase
            end
            CMD_CHECK: begin
                if (found_chain[NUM_LINES]) begin
                    rsp.take_interrupt = 1'b1;
                    rsp.vector_address = {vec_sum, 2'b00};
                end
            end
            default: rsp = '0;
        endcase
    end

    assign out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_rsp <= r_skid_valid ? r_skid_rsp : rsp;
        end
        if (!out_free && accept) begin
            r_skid_rsp <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

[rtl/core/pic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module pic_cell
    import pic_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_pic_cell_ctl i_ctl,
    input  wire logic          i_found,
    output logic               o_found,
    output logic               o_win,
    output logic               o_enable
);

    logic r_pend;
    logic r_en;
    logic n_pend;
    logic n_en;
    logic active;

    always_comb begin
        n_en   = i_ctl.load_en ? i_ctl.en_bit : r_en;
        n_pend = r_pend;
        if (i_ctl.load_en) begin
            n_pend = r_pend & i_ctl.en_bit;
        end
        if (i_ctl.clr) begin
            n_pend = 1'b0;
        end
        // A raise only sticks on a line that is already enabled.
        if (i_ctl.raise && r_en) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_en   <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_en   <= n_en;
        end
    end

    // Lower lines sit earlier in the chain, so the first active cell wins.
    assign active   = r_pend & r_en;
    assign o_win    = active & ~i_found;
    assign o_found  = active | i_found;
    assign o_enable = r_en;

endmodule

`default_nettype wire

[rtl/core/pic_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module pic_checker
    import pic_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_in_stall,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_pic_out o_out_rsp
);

    // A stalled response holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled response changed");

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output not empty after reset");

    // Input backpressure only appears behind a held response.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // A vector is only reported with a taken interrupt, and is word aligned.
    a_vector_qual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.take_interrupt || o_out_rsp.vector_address == 11'd0)
                        && o_out_rsp.vector_address[1:0] == 2'b00)
        else $error("vector without interrupt");

    // Read data and an interrupt never come from the same request.
    a_rsp_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.take_interrupt |-> o_out_rsp.read_data == 8'h00)
        else $error("read data on interrupt response");

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (.*);

`default_nettype wire

[verif/priority_interrupt_controller_test.sv]
`timescale 1ns / 1ps

module priority_interrupt_controller_test;
    import pic_pkg::*;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_REQUESTS = 215;
    localparam int HOLD_CYCLES    = 48;

    // Tracks the controller state and the responses that are still owed.
    class irq_scoreboard;
        logic [7:0] pending;
        logic [7:0] enabled;
        logic [7:0] base;
        t_pic_out   expected_responses[$];
        int         errors;

        function new();
            pending = '0;
            enabled = '0;
            base    = '0;
            errors  = 0;
        endfunction

        // Lowest line that is both pending and enabled; line 0 when none is.
        function void find_winner(output bit found, output logic [2:0] line);
            logic [7:0] active;
            active = pending & enabled;
            found  = 1'b0;
            line   = '0;
            for (int i = NUM_LINES - 1; i >= 0; i--) begin
                if (active[i]) begin
                    found = 1'b1;
                    line  = i[2:0];
                end
            end
        endfunction

        function t_pic_out predict_response(t_pic_in r);
            t_pic_out    rsp;
            bit          found;
            logic [2:0]  line;
            logic [10:0] slot;
            rsp = '0;
            case (r.cmd)
                CMD_WRITE: begin
                    if (r.port_addr == PORT_BASE) begin
                        base = r.write_data;
                    end else if (r.port_addr == PORT_ENABLE) begin
                        enabled = r.write_data;
                        pending = pending & enabled;
                    end else if (r.port_addr == PORT_STATUS) begin
                        pending = pending & ~r.write_data;
                    end
                end
                CMD_READ: begin
                    if (r.port_addr == PORT_BASE) begin
                        rsp.read_data = base;
                    end else if (r.port_addr == PORT_ENABLE) begin
                        rsp.read_data = enabled;
                    end else if (r.port_addr == PORT_STATUS) begin
                        find_winner(found, line);
                        rsp.read_data = 8'd1 << line;
                    end
                end
                CMD_RAISE: begin
                    if (enabled[r.line_number]) begin
                        pending[r.line_number] = 1'b1;
                    end
                end
                default: begin
                    find_winner(found, line);
                    if (found) begin
                        slot = {3'b000, base};
                        slot = slot + {8'd0, line};
                        rsp.take_interrupt = 1'b1;
                        rsp.vector_address = slot << 2;
                    end
                end
            endcase
            return rsp;
        endfunction

        function void note_request(t_pic_in r);
            expected_responses.push_back(predict_response(r));
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_response(t_pic_out got);
            t_pic_out want;
            if (expected_responses.size() == 0) begin
                report_mismatch($sformatf("response %h with no request outstanding", got));
            end else begin
                want = expected_responses.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, expected %h",
                                              got.read_data, want.read_data));
                if (got.take_interrupt !== want.take_interrupt)
                    report_mismatch($sformatf("take_interrupt %b, expected %b",
                                              got.take_interrupt, want.take_interrupt));
                if (got.vector_address !== want.vector_address)
                    report_mismatch($sformatf("vector_address %0d, expected %0d",
                                              got.vector_address, want.vector_address));
            end
        endtask
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     in_valid;
    logic     in_stall;
    t_pic_in  in_req;
    logic     out_valid;
    logic     out_stall;
    t_pic_out out_rsp;

    int idle_pct;
    int stall_pct;
    int hold_request;
    int hold_left;
    int cycle_count;

    irq_scoreboard board;

    priority_interrupt_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Requests are predicted before responses are checked on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall)
                board.note_request(in_req);
            if (out_valid && !out_stall)
                board.check_response(out_rsp);
        end
    end

    // The receiver owns its stall, including the long hold-off used to back
    // the block up until it stalls its input.
    initial begin
        out_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task send_request(t_pic_in r);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do
            @(posedge i_clk);
        while (in_stall);
        @(negedge i_clk);
    endtask

    task send_op(t_pic_cmd c, logic [7:0] port, logic [7:0] data, logic [2:0] line);
        t_pic_in r;
        r.cmd         = c;
        r.port_addr   = port;
        r.write_data  = data;
        r.line_number = line;
        send_request(r);
    endtask

    function automatic t_pic_in random_request();
        t_pic_in r;
        int      pick;
        pick = $urandom_range(99);
        if (pick < 25)      r.cmd = CMD_WRITE;
        else if (pick < 45) r.cmd = CMD_READ;
        else if (pick < 80) r.cmd = CMD_RAISE;
        else                r.cmd = CMD_CHECK;
        pick = $urandom_range(9);
        if (pick < 3)      r.port_addr = PORT_ENABLE;
        else if (pick < 5) r.port_addr = PORT_STATUS;
        else if (pick < 7) r.port_addr = PORT_BASE;
        else               r.port_addr = 8'($urandom_range(255));
        // A mostly open mask keeps raised lines pending long enough to matter.
        if ($urandom_range(3) == 0) r.write_data = 8'hFF;
        else                        r.write_data = 8'($urandom_range(255));
        r.line_number = 3'($urandom_range(7));
        return r;
    endfunction

    task run_directed();
        send_op(CMD_READ,  PORT_BASE,   8'hA5, 3'd5);
        send_op(CMD_READ,  PORT_ENABLE, 8'h5A, 3'd2);
        send_op(CMD_READ,  PORT_STATUS, 8'hFF, 3'd7);   // nothing pending reads as one
        send_op(CMD_CHECK, PORT_STATUS, 8'hFF, 3'd7);
        send_op(CMD_RAISE, PORT_STATUS, 8'hFF, 3'd3);   // masked line is dropped
        send_op(CMD_CHECK, 8'h00,       8'h00, 3'd0);
        send_op(CMD_WRITE, PORT_BASE,   8'hFF, 3'd7);
        send_op(CMD_WRITE, PORT_ENABLE, 8'hFF, 3'd0);
        send_op(CMD_RAISE, 8'hFF,       8'h00, 3'd7);
        send_op(CMD_CHECK, PORT_BASE,   8'hFF, 3'd1);   // largest vector
        send_op(CMD_READ,  PORT_STATUS, 8'h00, 3'd0);
        send_op(CMD_RAISE, PORT_BASE,   8'hFF, 3'd0);
        send_op(CMD_CHECK, PORT_ENABLE, 8'h00, 3'd6);   // lowest line wins
        send_op(CMD_WRITE, PORT_STATUS, 8'h01, 3'd7);
        send_op(CMD_CHECK, 8'hFF,       8'hFF, 3'd7);
        send_op(CMD_WRITE, PORT_ENABLE, 8'h7F, 3'd0);   // drops line seven
        send_op(CMD_CHECK, 8'h00,       8'h00, 3'd0);
        send_op(CMD_READ,  PORT_ENABLE, 8'h00, 3'd0);
        send_op(CMD_WRITE, 8'hB1,       8'h55, 3'd0);   // unknown port
        send_op(CMD_READ,  8'hFF,       8'h00, 3'd0);
        send_op(CMD_READ,  8'h00,       8'hFF, 3'd7);
        send_op(CMD_WRITE, PORT_STATUS, 8'hFF, 3'd0);
        send_op(CMD_WRITE, PORT_BASE,   8'h00, 3'd0);
        send_op(CMD_RAISE, 8'h00,       8'h00, 3'd4);
        send_op(CMD_CHECK, PORT_BASE,   8'h00, 3'd0);
    endtask

    task run_random_phase(int sender_idle, int receiver_stall, bit with_hold);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (with_hold && n == PHASE_REQUESTS / 3)
                hold_request = HOLD_CYCLES;
            send_request(random_request());
        end
    endtask

    initial begin
        board        = new();
        cycle_count  = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 0;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_req       = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        run_random_phase(0, 0, 1'b1);
        run_random_phase(76, 0, 1'b0);
        run_random_phase(0, 76, 1'b0);
        run_random_phase(17, 17, 1'b0);

        in_valid <= 1'b0;
        stall_pct = 0;
        while (board.expected_responses.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.expected_responses.size() != 0)
            board.report_mismatch($sformatf("%0d responses never arrived",
                                            board.expected_responses.size()));

        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
